@@ rtl/core/ttd_pkg.sv @@
// ---------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants of the touch tap / drag detector.
// ---------------------------------------------------------------------------
package ttd_pkg;

   // default widths of the event fields
   localparam int COORD_BITS_DEF  = 16;
   localparam int SEQ_ID_BITS_DEF = 32;

   // threshold register: whole pixels, scaled by 16 for Q12.4 compares
   localparam int THR_BITS   = 10;
   localparam int FRAC_BITS  = 4;
   localparam int LIM_BITS   = THR_BITS + FRAC_BITS;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(8);

   // register file
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_DRAG_THRESHOLD = '0;

   // event codes
   typedef enum logic [1:0] {
      ACT_DOWN   = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_MOVE   = 2'd2,
      ACT_UP     = 2'd3
   } action_type;

   // gesture codes
   typedef enum logic [1:0] {
      GEST_NONE = 2'd0,
      GEST_TAP  = 2'd1,
      GEST_DRAG = 2'd2
   } gesture_type;

   // decisions taken for one event
   typedef struct packed {
      logic accepted;
      logic clear_all;
      logic load_start;
      logic go_drag;
      logic drag_cont;
      logic up_delta;
      logic end_seq;
   } step_ctl_type;

endpackage

@@ rtl/core/ttd_req_if.sv @@
// ---------------------------------------------------------------------------
// ttd_req_if
// Touch event channel: valid/ready handshake with the event payload.
// ---------------------------------------------------------------------------
interface ttd_req_if #(
   parameter int COORD_BITS  = ttd_pkg::COORD_BITS_DEF,
   parameter int SEQ_ID_BITS = ttd_pkg::SEQ_ID_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [SEQ_ID_BITS-1:0]       sequence_id;
   logic                         has_position;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;

   modport source (
      output valid, action, sequence_id, has_position, pos_x, pos_y,
      input  ready
   );
   modport sink (
      input  valid, action, sequence_id, has_position, pos_x, pos_y,
      output ready
   );
endinterface

@@ rtl/core/ttd_rsp_if.sv @@
// ---------------------------------------------------------------------------
// ttd_rsp_if
// Gesture result channel: valid/ready handshake with the result payload.
// ---------------------------------------------------------------------------
interface ttd_rsp_if #(
   parameter int COORD_BITS = ttd_pkg::COORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic [1:0]                 gesture;
   logic                       delta_valid;
   logic signed [COORD_BITS:0] delta_x;
   logic signed [COORD_BITS:0] delta_y;
   logic                       drag_begin_valid;
   logic                       drag_begin;

   modport source (
      output valid, accepted, gesture, delta_valid, delta_x, delta_y,
             drag_begin_valid, drag_begin,
      input  ready
   );
   modport sink (
      input  valid, accepted, gesture, delta_valid, delta_x, delta_y,
             drag_begin_valid, drag_begin,
      output ready
   );
endinterface

@@ rtl/core/ttd_csr.sv @@
// ---------------------------------------------------------------------------
// ttd_csr
// APB-style register file holding the drag threshold.
// ---------------------------------------------------------------------------
module ttd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ttd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ttd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ttd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output logic [ttd_pkg::THR_BITS-1:0]        drag_threshold
);

   logic [ttd_pkg::THR_BITS-1:0] thr_ff;
   logic [ttd_pkg::THR_BITS-1:0] thr_in;
   logic                         wr_hit;

   // write strobe on the access phase
   assign wr_hit = psel && penable && pwrite && (paddr == ttd_pkg::CSR_ADDR_DRAG_THRESHOLD);
   assign thr_in = wr_hit ? pwdata[ttd_pkg::THR_BITS-1:0] : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ttd_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      unique case (paddr)
         ttd_pkg::CSR_ADDR_DRAG_THRESHOLD: begin
            prdata = ttd_pkg::CSR_DATA_BITS'(thr_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign pready         = 1'b1;
   assign drag_threshold = thr_ff;

endmodule

@@ rtl/core/ttd_in_stage.sv @@
// ---------------------------------------------------------------------------
// ttd_in_stage
// Input register for touch event beats; refills in the cycle it drains.
// ---------------------------------------------------------------------------
module ttd_in_stage #(
   parameter int COORD_BITS  = ttd_pkg::COORD_BITS_DEF,
   parameter int SEQ_ID_BITS = ttd_pkg::SEQ_ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   ttd_req_if.sink                      req_chan,
   input  logic                         take,
   output logic                         ev_valid,
   output ttd_pkg::action_type          ev_action,
   output logic [SEQ_ID_BITS-1:0]       ev_seq,
   output logic                         ev_has_pos,
   output logic signed [COORD_BITS-1:0] ev_x,
   output logic signed [COORD_BITS-1:0] ev_y
);

   logic                         valid_ff;
   logic                         valid_in;
   logic                         load;
   logic [1:0]                   act_ff;
   logic [SEQ_ID_BITS-1:0]       seq_ff;
   logic                         pos_ff;
   logic signed [COORD_BITS-1:0] x_ff;
   logic signed [COORD_BITS-1:0] y_ff;

   // room when empty or when the held beat moves on this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         act_ff <= req_chan.action;
         seq_ff <= req_chan.sequence_id;
         pos_ff <= req_chan.has_position;
         x_ff   <= req_chan.pos_x;
         y_ff   <= req_chan.pos_y;
      end
   end

   assign ev_valid   = valid_ff;
   assign ev_action  = ttd_pkg::action_type'(act_ff);
   assign ev_seq     = seq_ff;
   assign ev_has_pos = pos_ff;
   assign ev_x       = x_ff;
   assign ev_y       = y_ff;

endmodule

@@ rtl/core/ttd_gesture.sv @@
// ---------------------------------------------------------------------------
// ttd_gesture
// Gesture state, per-event update and the result register.
// ---------------------------------------------------------------------------
module ttd_gesture #(
   parameter int COORD_BITS  = ttd_pkg::COORD_BITS_DEF,
   parameter int SEQ_ID_BITS = ttd_pkg::SEQ_ID_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ttd_pkg::THR_BITS-1:0]  drag_threshold,
   input  logic                          ev_valid,
   input  ttd_pkg::action_type           ev_action,
   input  logic [SEQ_ID_BITS-1:0]        ev_seq,
   input  logic                          ev_has_pos,
   input  logic signed [COORD_BITS-1:0]  ev_x,
   input  logic signed [COORD_BITS-1:0]  ev_y,
   output logic                          take,
   ttd_rsp_if.source                     rsp_chan
);

   localparam int ABS_BITS = COORD_BITS + 1;
   localparam int LIM_BITS = ttd_pkg::LIM_BITS;
   localparam int CMP_BITS = (ABS_BITS > LIM_BITS) ? ABS_BITS : LIM_BITS;
   localparam int SQ_BITS  = 2 * LIM_BITS;

   // gesture state
   logic                         active_ff, active_in;
   logic [SEQ_ID_BITS-1:0]       aseq_ff, aseq_in;
   ttd_pkg::gesture_type         gest_ff, gest_in;
   logic                         start_valid_ff, start_valid_in;
   logic signed [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [COORD_BITS-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic                         dheld_ff, dheld_in;
   logic signed [COORD_BITS:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic                         bheld_ff, bheld_in;
   logic                         bflag_ff, bflag_in;

   // result register
   logic                         rvalid_ff, rvalid_in;
   logic                         racc_ff;
   ttd_pkg::gesture_type         rgest_ff;
   logic                         rdv_ff;
   logic signed [COORD_BITS:0]   rdx_ff, rdy_ff;
   logic                         rbv_ff, rbeg_ff;

   ttd_pkg::step_ctl_type        ctl;

   // distance datapath
   logic signed [COORD_BITS:0]   sdx, sdy;
   logic [ABS_BITS-1:0]          ax, ay;
   logic [CMP_BITS-1:0]          ax_ext, ay_ext, lim_ext;
   logic [LIM_BITS-1:0]          lim, ax_op, ay_op;
   logic [SQ_BITS-1:0]           ax_sq, ay_sq, lim_sq;
   logic [SQ_BITS:0]             dist_sq;
   logic                         beyond;
   logic                         foreign, pos_ok, is_mu;
   logic signed [COORD_BITS-1:0] base_x, base_y;

   // event moves into the result register when that register has room
   assign take = ev_valid && (!rvalid_ff || rsp_chan.ready);

   // offset from the start point and squared-distance test
   assign sdx = {ev_x[COORD_BITS-1], ev_x} - {start_x_ff[COORD_BITS-1], start_x_ff};
   assign sdy = {ev_y[COORD_BITS-1], ev_y} - {start_y_ff[COORD_BITS-1], start_y_ff};
   assign ax  = sdx[COORD_BITS] ? ABS_BITS'(-sdx) : ABS_BITS'(sdx);
   assign ay  = sdy[COORD_BITS] ? ABS_BITS'(-sdy) : ABS_BITS'(sdy);
   assign lim     = {drag_threshold, {ttd_pkg::FRAC_BITS{1'b0}}};
   assign ax_ext  = CMP_BITS'(ax);
   assign ay_ext  = CMP_BITS'(ay);
   assign lim_ext = CMP_BITS'(lim);
   // squares only matter when both offsets are within the limit
   assign ax_op   = ax_ext[LIM_BITS-1:0];
   assign ay_op   = ay_ext[LIM_BITS-1:0];
   assign ax_sq   = SQ_BITS'(ax_op) * SQ_BITS'(ax_op);
   assign ay_sq   = SQ_BITS'(ay_op) * SQ_BITS'(ay_op);
   assign lim_sq  = SQ_BITS'(lim) * SQ_BITS'(lim);
   assign dist_sq = {1'b0, ax_sq} + {1'b0, ay_sq};
   assign beyond  = (ax_ext > lim_ext) || (ay_ext > lim_ext) || (dist_sq > {1'b0, lim_sq});

   // event decisions
   always_comb begin
      ctl     = '0;
      foreign = active_ff && (aseq_ff != ev_seq);
      is_mu   = (ev_action == ttd_pkg::ACT_MOVE) || (ev_action == ttd_pkg::ACT_UP);
      pos_ok  = ev_has_pos && start_valid_ff;
      ctl.accepted = !foreign && !(is_mu && !active_ff);
      unique case (ev_action)
         ttd_pkg::ACT_DOWN: begin
            ctl.clear_all  = ctl.accepted;
            ctl.load_start = ctl.accepted && ev_has_pos;
         end
         ttd_pkg::ACT_CANCEL: begin
            ctl.clear_all = ctl.accepted;
         end
         ttd_pkg::ACT_MOVE: begin
            ctl.clear_all = ctl.accepted && !pos_ok;
            ctl.go_drag   = ctl.accepted && pos_ok && (gest_ff != ttd_pkg::GEST_DRAG) && beyond;
            ctl.drag_cont = ctl.accepted && pos_ok && (gest_ff == ttd_pkg::GEST_DRAG);
         end
         ttd_pkg::ACT_UP: begin
            ctl.clear_all = ctl.accepted && !pos_ok;
            ctl.up_delta  = ctl.accepted && pos_ok && (gest_ff == ttd_pkg::GEST_DRAG);
            ctl.end_seq   = ctl.accepted;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // gesture next state
   always_comb begin
      gest_in = gest_ff;
      if (take) begin
         if (ctl.load_start) begin
            gest_in = ttd_pkg::GEST_TAP;
         end else if (ctl.clear_all) begin
            gest_in = ttd_pkg::GEST_NONE;
         end else if (ctl.go_drag) begin
            gest_in = ttd_pkg::GEST_DRAG;
         end
      end
   end

   // positions, deltas and flags
   always_comb begin
      active_in      = active_ff;
      aseq_in        = aseq_ff;
      start_valid_in = start_valid_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      ref_x_in       = ref_x_ff;
      ref_y_in       = ref_y_ff;
      dheld_in       = dheld_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      bheld_in       = bheld_ff;
      bflag_in       = bflag_ff;
      // first drag move measures from the start point
      base_x = ctl.go_drag ? start_x_ff : ref_x_ff;
      base_y = ctl.go_drag ? start_y_ff : ref_y_ff;
      if (take) begin
         if (ctl.clear_all) begin
            active_in      = 1'b0;
            aseq_in        = '0;
            start_valid_in = 1'b0;
            start_x_in     = '0;
            start_y_in     = '0;
            ref_x_in       = '0;
            ref_y_in       = '0;
            dheld_in       = 1'b0;
            dx_in          = '0;
            dy_in          = '0;
            bheld_in       = 1'b0;
            bflag_in       = 1'b0;
         end
         if (ctl.load_start) begin
            active_in      = 1'b1;
            aseq_in        = ev_seq;
            start_valid_in = 1'b1;
            start_x_in     = ev_x;
            start_y_in     = ev_y;
         end
         if (ctl.go_drag || ctl.drag_cont || ctl.up_delta) begin
            dheld_in = 1'b1;
            dx_in    = {ev_x[COORD_BITS-1], ev_x} - {base_x[COORD_BITS-1], base_x};
            dy_in    = {ev_y[COORD_BITS-1], ev_y} - {base_y[COORD_BITS-1], base_y};
         end
         if (ctl.go_drag || ctl.drag_cont) begin
            bheld_in = 1'b1;
            bflag_in = ctl.go_drag;
            ref_x_in = ev_x;
            ref_y_in = ev_y;
         end
         if (ctl.end_seq) begin
            active_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         aseq_ff        <= '0;
         gest_ff        <= ttd_pkg::GEST_NONE;
         start_valid_ff <= 1'b0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         ref_x_ff       <= '0;
         ref_y_ff       <= '0;
         dheld_ff       <= 1'b0;
         dx_ff          <= '0;
         dy_ff          <= '0;
         bheld_ff       <= 1'b0;
         bflag_ff       <= 1'b0;
      end else begin
         active_ff      <= active_in;
         aseq_ff        <= aseq_in;
         gest_ff        <= gest_in;
         start_valid_ff <= start_valid_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         ref_x_ff       <= ref_x_in;
         ref_y_ff       <= ref_y_in;
         dheld_ff       <= dheld_in;
         dx_ff          <= dx_in;
         dy_ff          <= dy_in;
         bheld_ff       <= bheld_in;
         bflag_ff       <= bflag_in;
      end
   end

   // result beat valid
   assign rvalid_in = take || (rvalid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         racc_ff  <= ctl.accepted;
         rgest_ff <= gest_in;
         rdv_ff   <= dheld_in;
         rdx_ff   <= dheld_in ? dx_in : '0;
         rdy_ff   <= dheld_in ? dy_in : '0;
         rbv_ff   <= bheld_in;
         rbeg_ff  <= bheld_in && bflag_in;
      end
   end

   assign rsp_chan.valid            = rvalid_ff;
   assign rsp_chan.accepted         = racc_ff;
   assign rsp_chan.gesture          = rgest_ff;
   assign rsp_chan.delta_valid      = rdv_ff;
   assign rsp_chan.delta_x          = rdx_ff;
   assign rsp_chan.delta_y          = rdy_ff;
   assign rsp_chan.drag_begin_valid = rbv_ff;
   assign rsp_chan.drag_begin       = rbeg_ff;

`ifndef SYNTHESIS
   // a rejected event leaves the tracked sequence alone
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (take && !ctl.accepted) |=> ($stable(active_ff) && $stable(aseq_ff) && $stable(gest_ff)))
      else $error("rejected event changed the sequence state");

   // drag flags and deltas only exist while in a drag
   a_begin_in_drag: assert property (@(posedge clock) disable iff (reset)
      (bheld_ff || dheld_ff) |-> (gest_ff == ttd_pkg::GEST_DRAG))
      else $error("drag flag or delta held outside a drag");

   // a start point exists exactly when a gesture is under way
   a_start_gesture: assert property (@(posedge clock) disable iff (reset)
      start_valid_ff == (gest_ff != ttd_pkg::GEST_NONE))
      else $error("start point and gesture disagree");

   // a drag-begin beat carries a delta
   a_begin_delta: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && rbeg_ff) |-> (rdv_ff && rbv_ff && (rgest_ff == ttd_pkg::GEST_DRAG)))
      else $error("drag-begin beat without delta");
`endif

endmodule

@@ rtl/core/touch_tap_drag_detector_top.sv @@
// ---------------------------------------------------------------------------
// touch_tap_drag_detector_top
// Tracks one touch sequence and classifies it as tap or drag, with deltas.
//
//   channel    direction  handshake        contents
//   req_chan   in         valid/ready      action, sequence id, position
//   rsp_chan   out        valid/ready      accepted, gesture, delta, drag begin
//   apb        in         psel/penable     drag threshold register
//
// One event per cycle sustained while the result side is ready; a request beat
// reaches the result beat through the input register, then the result register.
// The per-event update is one pass through a squared-distance compare.
// Reset is synchronous and clears the gesture state; threshold returns to 8.
// A stalled result holds its register; the input register still takes one
// more event, and request ready drops only when both registers are full.
// ---------------------------------------------------------------------------
module touch_tap_drag_detector_top #(
   parameter int COORD_BITS  = ttd_pkg::COORD_BITS_DEF,
   parameter int SEQ_ID_BITS = ttd_pkg::SEQ_ID_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ttd_req_if.sink                           req_chan,
   ttd_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ttd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [ttd_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [ttd_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);

   logic [ttd_pkg::THR_BITS-1:0] drag_threshold;
   logic                         take;
   logic                         ev_valid;
   ttd_pkg::action_type          ev_action;
   logic [SEQ_ID_BITS-1:0]       ev_seq;
   logic                         ev_has_pos;
   logic signed [COORD_BITS-1:0] ev_x;
   logic signed [COORD_BITS-1:0] ev_y;

   // threshold register
   ttd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .drag_threshold (drag_threshold)
   );

   // event input register
   ttd_in_stage #(
      .COORD_BITS  (COORD_BITS),
      .SEQ_ID_BITS (SEQ_ID_BITS)
   ) u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .ev_valid   (ev_valid),
      .ev_action  (ev_action),
      .ev_seq     (ev_seq),
      .ev_has_pos (ev_has_pos),
      .ev_x       (ev_x),
      .ev_y       (ev_y)
   );

   // gesture tracking and result register
   ttd_gesture #(
      .COORD_BITS  (COORD_BITS),
      .SEQ_ID_BITS (SEQ_ID_BITS)
   ) u_gesture (
      .clock          (clock),
      .reset          (reset),
      .drag_threshold (drag_threshold),
      .ev_valid       (ev_valid),
      .ev_action      (ev_action),
      .ev_seq         (ev_seq),
      .ev_has_pos     (ev_has_pos),
      .ev_x           (ev_x),
      .ev_y           (ev_y),
      .take           (take),
      .rsp_chan       (rsp_chan)
   );

endmodule

@@ tb/ttd_gesture_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ttd_gesture_checker
// Watches the touch event and gesture result channels of the tap / drag
// detector. It keeps its own copy of the tracking state and the drag
// threshold, predicts the result of every handshaken event beat, and compares
// each result beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module ttd_gesture_checker
   import ttd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   ttd_req_if                       req_mon,
   ttd_rsp_if                       rsp_mon,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output int                       error_count,
   output int                       pending_count
);

   localparam int CW = COORD_BITS_DEF;
   localparam int SW = SEQ_ID_BITS_DEF;

   typedef struct packed {
      logic                accepted;
      gesture_type         gesture;
      logic                delta_valid;
      logic signed [CW:0]  delta_x;
      logic signed [CW:0]  delta_y;
      logic                begin_valid;
      logic                begin_flag;
   } gesture_result_type;

   // tracked touch state
   logic [THR_BITS-1:0]  threshold;
   logic                 seq_active;
   logic [SW-1:0]        seq_owner;
   gesture_type          gest;
   logic                 start_ok;
   logic signed [CW-1:0] start_x, start_y;
   logic signed [CW-1:0] ref_x, ref_y;
   logic                 delta_held;
   logic signed [CW:0]   held_dx, held_dy;
   logic                 begin_held;
   logic                 begin_flag;

   gesture_result_type pending_gestures[$];
   gesture_result_type want, got;
   int                 result_index;

   function automatic void clear_tracking();
      seq_active = 1'b0;
      seq_owner  = '0;
      gest       = GEST_NONE;
      start_ok   = 1'b0;
      start_x    = '0;
      start_y    = '0;
      ref_x      = '0;
      ref_y      = '0;
      delta_held = 1'b0;
      held_dx    = '0;
      held_dy    = '0;
      begin_held = 1'b0;
      begin_flag = 1'b0;
   endfunction

   // advance the tracking state by one event and return the result it shows
   function automatic gesture_result_type predict_gesture(
      action_type act, logic [SW-1:0] sid, logic has_pos,
      logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      gesture_result_type r;
      logic               ok;
      longint             dx, dy, lim;
      ok = 1'b1;
      if (seq_active && seq_owner != sid) begin
         ok = 1'b0;
      end else if (act == ACT_DOWN) begin
         clear_tracking();
         if (has_pos) begin
            gest       = GEST_TAP;
            start_ok   = 1'b1;
            start_x    = x;
            start_y    = y;
            seq_active = 1'b1;
            seq_owner  = sid;
         end
      end else if (act == ACT_CANCEL) begin
         clear_tracking();
      end else if (!seq_active) begin
         ok = 1'b0;
      end else if (!(has_pos && start_ok)) begin
         // move or up without a position wipes everything
         clear_tracking();
      end else if (act == ACT_MOVE) begin
         dx  = longint'(x) - longint'(start_x);
         dy  = longint'(y) - longint'(start_y);
         lim = longint'(threshold) * 16;
         if (gest != GEST_DRAG && dx * dx + dy * dy > lim * lim) begin
            gest       = GEST_DRAG;
            ref_x      = start_x;
            ref_y      = start_y;
            begin_held = 1'b1;
            begin_flag = 1'b1;
         end else if (gest == GEST_DRAG) begin
            begin_held = 1'b1;
            begin_flag = 1'b0;
         end
         if (gest == GEST_DRAG) begin
            delta_held = 1'b1;
            held_dx    = {x[CW-1], x} - {ref_x[CW-1], ref_x};
            held_dy    = {y[CW-1], y} - {ref_y[CW-1], ref_y};
            ref_x      = x;
            ref_y      = y;
         end
      end else begin
         // up: last delta only when dragging, tap stays tap
         if (gest == GEST_DRAG) begin
            delta_held = 1'b1;
            held_dx    = {x[CW-1], x} - {ref_x[CW-1], ref_x};
            held_dy    = {y[CW-1], y} - {ref_y[CW-1], ref_y};
         end
         seq_active = 1'b0;
      end
      r.accepted    = ok;
      r.gesture     = gest;
      r.delta_valid = delta_held;
      r.delta_x     = delta_held ? held_dx : '0;
      r.delta_y     = delta_held ? held_dy : '0;
      r.begin_valid = begin_held;
      r.begin_flag  = begin_held & begin_flag;
      return r;
   endfunction

   // threshold snoop, prediction on event beats, compare on result beats
   always @(posedge clock) begin
      if (reset) begin
         clear_tracking();
         threshold = THR_RESET;
         pending_gestures.delete();
         result_index = 0;
         error_count  <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_ADDR_DRAG_THRESHOLD)
            threshold = pwdata[THR_BITS-1:0];
         if (req_mon.valid && req_mon.ready)
            pending_gestures.push_back(predict_gesture(action_type'(req_mon.action),
               req_mon.sequence_id, req_mon.has_position, req_mon.pos_x, req_mon.pos_y));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.accepted    = rsp_mon.accepted;
            got.gesture     = gesture_type'(rsp_mon.gesture);
            got.delta_valid = rsp_mon.delta_valid;
            got.delta_x     = rsp_mon.delta_x;
            got.delta_y     = rsp_mon.delta_y;
            got.begin_valid = rsp_mon.drag_begin_valid;
            got.begin_flag  = rsp_mon.drag_begin;
            if (pending_gestures.size() == 0) begin
               if (error_count < 10)
                  $display("result beat %0d arrived with no event outstanding", result_index);
               error_count <= error_count + 1;
            end else begin
               want = pending_gestures.pop_front();
               if (got !== want) begin
                  if (error_count < 10) begin
                     $display("result beat %0d mismatch", result_index);
                     $display("  expected acc=%0b gest=%0d dv=%0b dx=%0d dy=%0d bv=%0b b=%0b",
                        want.accepted, want.gesture, want.delta_valid,
                        $signed(want.delta_x), $signed(want.delta_y),
                        want.begin_valid, want.begin_flag);
                     $display("  actual   acc=%0b gest=%0d dv=%0b dx=%0d dy=%0d bv=%0b b=%0b",
                        got.accepted, got.gesture, got.delta_valid,
                        $signed(got.delta_x), $signed(got.delta_y),
                        got.begin_valid, got.begin_flag);
                  end
                  error_count <= error_count + 1;
               end
            end
            result_index++;
         end
      end
      pending_count <= pending_gestures.size();
   end

endmodule

@@ tb/tb_touch_tap_drag_detector_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_touch_tap_drag_detector_top
// Drives touch events into the tap / drag detector: a directed pass over the
// corner cases, then random touch sequences under several drag thresholds,
// with random gaps on both channels and one long result stall. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_touch_tap_drag_detector_top;
   import ttd_pkg::*;

   localparam int CW           = COORD_BITS_DEF;
   localparam int SW           = SEQ_ID_BITS_DEF;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_EVENTS = 330;

   logic                     clock;
   logic                     reset;
   logic                     psel, penable, pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   ttd_req_if req_bus ();
   ttd_rsp_if rsp_bus ();

   int  check_errors;
   int  pending_count;
   int  csr_errors;
   int  events_sent;
   int  quiet_cycles;
   bit  idle_on;
   bit  hold_results;
   logic [THR_BITS-1:0] thr_now;
   int  thr_plan[6];

   touch_tap_drag_detector_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   ttd_gesture_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .error_count   (check_errors),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one event beat, with a random gap in front of it while gaps are on
   task automatic send_event(action_type act, logic [SW-1:0] sid, logic has_pos,
                             logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      if (idle_on)
         while ($urandom_range(99) < 19) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.sequence_id  <= sid;
      req_bus.has_position <= has_pos;
      req_bus.pos_x        <= x;
      req_bus.pos_y        <= y;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      events_sent++;
   endtask

   // wait until every event has its result
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // threshold write, then read back
   task automatic set_threshold(logic [THR_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_DRAG_THRESHOLD;
      pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[THR_BITS-1:0] !== value) begin
         $display("threshold readback %0d, wrote %0d", prdata[THR_BITS-1:0], value);
         csr_errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      thr_now = value;
   endtask

   function automatic logic [SW-1:0] pick_sequence_id();
      case ($urandom_range(9))
         0:       return SW'($urandom_range(3));
         1:       return {SW{1'b1}} - SW'($urandom_range(3));
         default: return SW'($urandom);
      endcase
   endfunction

   // point around c, mostly within a couple of thresholds
   function automatic logic signed [CW-1:0] near_point(logic signed [CW-1:0] c);
      int span, off;
      span = int'(thr_now) * 32 + 32;
      if ($urandom_range(9) == 0) return CW'($urandom);
      off = int'($urandom_range(2 * span)) - span;
      return CW'(int'(c) + off);
   endfunction

   // random event, on the given or a foreign sequence; a down that may have
   // opened a sequence is closed right away
   task automatic send_noise(logic [SW-1:0] sid);
      action_type   act;
      logic [SW-1:0] id;
      logic         hp;
      act = action_type'($urandom_range(3));
      id  = $urandom_range(1) ? sid : (sid ^ (SW'($urandom) | SW'(1)));
      hp  = 1'($urandom_range(1));
      send_event(act, id, hp, CW'($urandom), CW'($urandom));
      if (act == ACT_DOWN && hp)
         send_event(ACT_CANCEL, id, 1'($urandom_range(1)), CW'($urandom), CW'($urandom));
   endtask

   // mostly complete touch sequences with random content, some noise
   task automatic run_touch_sequences(int count);
      int                   stop_at, r, moves;
      logic [SW-1:0]        sid;
      logic signed [CW-1:0] sx, sy;
      stop_at = events_sent + count;
      while (events_sent < stop_at) begin
         sid = pick_sequence_id();
         if ($urandom_range(99) < 75) begin
            sx = CW'($urandom);
            sy = CW'($urandom);
            send_event(ACT_DOWN, sid, 1'b1, sx, sy);
            moves = $urandom_range(0, 8);
            repeat (moves) begin
               r = $urandom_range(99);
               if (r < 8) begin
                  send_noise(sid);
               end else if (r < 11) begin
                  send_event(ACT_MOVE, sid, 1'b0, CW'($urandom), CW'($urandom));
               end else if (r < 14) begin
                  sx = near_point(sx);
                  sy = near_point(sy);
                  send_event(ACT_DOWN, sid, 1'b1, sx, sy);
               end else begin
                  send_event(ACT_MOVE, sid, 1'b1, near_point(sx), near_point(sy));
               end
            end
            r = $urandom_range(99);
            if (r < 90)
               send_event(ACT_UP, sid, r < 84, near_point(sx), near_point(sy));
            else
               send_event(ACT_CANCEL, sid, 1'($urandom_range(1)), CW'($urandom),
                          CW'($urandom));
         end else begin
            send_noise(sid);
         end
      end
   endtask

   // result side ready, with random stalls and one long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         rsp_bus.ready <= !(idle_on && $urandom_range(99) < 19);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_DOWN;
      req_bus.sequence_id  <= '0;
      req_bus.has_position <= 1'b0;
      req_bus.pos_x        <= '0;
      req_bus.pos_y        <= '0;
      quiet_cycles         = 0;
      csr_errors           = 0;
      events_sent          = 0;
      idle_on              = 1'b1;
      hold_results         = 1'b0;
      thr_now              = THR_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner cases under the reset threshold of 8 pixels (128 in Q12.4)
      send_event(ACT_MOVE,   5, 1'b1, 0, 0);          // move with nothing active
      send_event(ACT_UP,     5, 1'b1, 0, 0);          // up with nothing active
      send_event(ACT_CANCEL, 5, 1'b0, 0, 0);          // cancel with nothing active
      send_event(ACT_DOWN,   5, 1'b0, 0, 0);          // down without position
      send_event(ACT_DOWN,   5, 1'b1, 0, 0);
      send_event(ACT_MOVE,   5, 1'b1, 16, -16);
      send_event(ACT_DOWN,   6, 1'b1, 3, 3);          // foreign sequence
      send_event(ACT_MOVE,   5, 1'b1, 128, 0);        // right on the threshold
      send_event(ACT_MOVE,   5, 1'b1, 90, 90);
      send_event(ACT_MOVE,   5, 1'b1, 91, -91);       // diagonal just past it
      send_event(ACT_MOVE,   5, 1'b1, -32768, 32767);
      send_event(ACT_MOVE,   5, 1'b1, 32767, -32768); // widest deltas
      send_event(ACT_CANCEL, 6, 1'b0, 0, 0);          // foreign cancel
      send_event(ACT_UP,     5, 1'b1, 0, 0);
      send_event(ACT_MOVE,   5, 1'b1, 1, 1);          // after the sequence ended
      send_event(ACT_DOWN,   32'hFFFF_FFFF, 1'b1, 32767, 32767);
      send_event(ACT_UP,     32'hFFFF_FFFF, 1'b1, -32768, -32768); // up on a tap
      send_event(ACT_DOWN,   0, 1'b1, -32768, -32768);
      send_event(ACT_DOWN,   0, 1'b1, 5, 5);          // re-arm on the same sequence
      send_event(ACT_MOVE,   0, 1'b1, 200, 5);
      send_event(ACT_MOVE,   0, 1'b0, 0, 0);          // move without position
      send_event(ACT_DOWN,   0, 1'b1, 0, 0);
      send_event(ACT_MOVE,   0, 1'b1, -129, 0);
      send_event(ACT_UP,     0, 1'b0, 0, 0);          // up without position
      send_event(ACT_DOWN,   9, 1'b1, 0, 0);
      send_event(ACT_CANCEL, 9, 1'b1, 7, 7);

      // random sequences under a range of thresholds
      thr_plan = '{0, 1023, 1, 0, 300, 8};
      thr_plan[3] = $urandom_range(2, 1022);
      foreach (thr_plan[i]) begin
         drain_results();
         set_threshold(THR_BITS'(thr_plan[i]));
         idle_on = (i != 4);
         if (i == 1) hold_results = 1'b1;
         run_touch_sequences(PHASE_EVENTS);
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (check_errors == 0 && csr_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
